FILE: sv/akwb_pkg.sv
// shared types, constants and the filter microprogram
`timescale 1ns / 1ps

package akwb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_ITERS = 64 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);
    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] PC_PRED_END = PC_W'(23);
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(89);
    localparam int ADDR_W = 5;

    localparam logic [16:0] STEP_TIME_RST = 17'd1311;
    localparam logic [30:0] ALT_PV_RST = 31'd66;
    localparam logic [30:0] VEL_PV_RST = 31'd66;
    localparam logic [30:0] ALT_MV_RST = 31'd655;
    localparam logic [30:0] VEL_MV_RST = 31'd655;
    localparam logic [16:0] BIAS_GAIN_RST = 17'd6554;
    localparam logic [15:0] SETTLE_RST = 16'd100;

    typedef enum logic [1:0] {
        OPC_INIT    = 2'd0,
        OPC_PREDICT = 2'd1,
        OPC_UPDATE  = 2'd2,
        OPC_NONE    = 2'd3
    } t_opc;

    typedef enum logic [2:0] {
        REG_STEP_TIME = 3'd0,
        REG_ALT_PV    = 3'd1,
        REG_VEL_PV    = 3'd2,
        REG_ALT_MV    = 3'd3,
        REG_VEL_MV    = 3'd4,
        REG_BIAS_GAIN = 3'd5,
        REG_SETTLE    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] accel_down;
        logic signed [31:0] alt_meas;
        logic signed [31:0] vel_meas;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] alt_est;
        logic signed [31:0] vel_est;
        logic signed [31:0] bias_est;
        logic               settled;
    } t_out_word;

    typedef struct packed {
        logic [16:0] step_time;
        logic [30:0] alt_process_var;
        logic [30:0] vel_process_var;
        logic [30:0] alt_meas_var;
        logic [30:0] vel_meas_var;
        logic [16:0] bias_gain;
        logic [15:0] settle_count;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP, OP_MUL, OP_LD, OP_ACCADD, OP_ACCSUB, OP_RND, OP_ADD, OP_SUB,
        OP_DET, OP_DIV, OP_DIVWR, OP_PCOMMIT, OP_LEARN, OP_BADD, OP_BUMP
    } t_op;

    typedef enum logic [5:0] {
        SEL_ZERO, SEL_H, SEL_V, SEL_PA, SEL_PC, SEL_PV, SEL_PRI, SEL_BIAS,
        SEL_DT, SEL_QA, SEL_QV, SEL_RA, SEL_RV, SEL_GAIN, SEL_ACC, SEL_ZH, SEL_ZV,
        SEL_T, SEL_HP, SEL_VP, SEL_P00, SEL_P01, SEL_P11, SEL_S00, SEL_S11,
        SEL_K00, SEL_K01, SEL_K10, SEL_K11, SEL_Y0, SEL_Y1, SEL_C0, SEL_C1
    } t_sel;

    typedef struct packed {
        t_op  op;
        t_sel a;
        t_sel b;
        t_sel dst;
    } t_instr;

    typedef struct packed {
        t_op  op;
        t_sel a;
        t_sel b;
        t_sel dst;
        logic latch;
        logic init;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    function automatic t_instr mk(input t_op op, input t_sel a, input t_sel b,
                                  input t_sel dst);
        t_instr i;
        i.op = op;
        i.a = a;
        i.b = b;
        i.dst = dst;
        return i;
    endfunction

    // microprogram: prediction, then gain, correction and bias learning
    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr i;
        case (pc)
            7'd0:  i = mk(OP_MUL, SEL_V, SEL_DT, SEL_ZERO);
            7'd1:  i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd2:  i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd3:  i = mk(OP_SUB, SEL_H, SEL_T, SEL_HP);
            7'd4:  i = mk(OP_ADD, SEL_ACC, SEL_BIAS, SEL_T);
            7'd5:  i = mk(OP_MUL, SEL_T, SEL_DT, SEL_ZERO);
            7'd6:  i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd7:  i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd8:  i = mk(OP_ADD, SEL_V, SEL_T, SEL_VP);
            7'd9:  i = mk(OP_MUL, SEL_DT, SEL_PV, SEL_ZERO);
            7'd10: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd11: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd12: i = mk(OP_SUB, SEL_PC, SEL_T, SEL_P01);
            7'd13: i = mk(OP_MUL, SEL_DT, SEL_PC, SEL_ZERO);
            7'd14: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd15: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd16: i = mk(OP_SUB, SEL_PA, SEL_T, SEL_P00);
            7'd17: i = mk(OP_MUL, SEL_DT, SEL_P01, SEL_ZERO);
            7'd18: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd19: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd20: i = mk(OP_SUB, SEL_P00, SEL_T, SEL_P00);
            7'd21: i = mk(OP_ADD, SEL_P00, SEL_QA, SEL_P00);
            7'd22: i = mk(OP_ADD, SEL_PV, SEL_QV, SEL_P11);
            7'd23: i = mk(OP_PCOMMIT, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd24: i = mk(OP_ADD, SEL_P00, SEL_RA, SEL_S00);
            7'd25: i = mk(OP_ADD, SEL_P11, SEL_RV, SEL_S11);
            7'd26: i = mk(OP_MUL, SEL_S00, SEL_S11, SEL_ZERO);
            7'd27: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd28: i = mk(OP_MUL, SEL_P01, SEL_P01, SEL_ZERO);
            7'd29: i = mk(OP_ACCSUB, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd30: i = mk(OP_DET, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd31: i = mk(OP_MUL, SEL_P00, SEL_S11, SEL_ZERO);
            7'd32: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd33: i = mk(OP_MUL, SEL_P01, SEL_P01, SEL_ZERO);
            7'd34: i = mk(OP_ACCSUB, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd35: i = mk(OP_DIV, SEL_ZERO, SEL_ZERO, SEL_K00);
            7'd36: i = mk(OP_MUL, SEL_P01, SEL_S00, SEL_ZERO);
            7'd37: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd38: i = mk(OP_MUL, SEL_P00, SEL_P01, SEL_ZERO);
            7'd39: i = mk(OP_ACCSUB, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd40: i = mk(OP_DIV, SEL_ZERO, SEL_ZERO, SEL_K01);
            7'd41: i = mk(OP_MUL, SEL_P01, SEL_S11, SEL_ZERO);
            7'd42: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd43: i = mk(OP_MUL, SEL_P11, SEL_P01, SEL_ZERO);
            7'd44: i = mk(OP_ACCSUB, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd45: i = mk(OP_DIV, SEL_ZERO, SEL_ZERO, SEL_K10);
            7'd46: i = mk(OP_MUL, SEL_P11, SEL_S00, SEL_ZERO);
            7'd47: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd48: i = mk(OP_MUL, SEL_P01, SEL_P01, SEL_ZERO);
            7'd49: i = mk(OP_ACCSUB, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd50: i = mk(OP_DIV, SEL_ZERO, SEL_ZERO, SEL_K11);
            7'd51: i = mk(OP_SUB, SEL_ZH, SEL_PRI, SEL_Y0);
            7'd52: i = mk(OP_SUB, SEL_ZV, SEL_VP, SEL_Y1);
            7'd53: i = mk(OP_MUL, SEL_K00, SEL_Y0, SEL_ZERO);
            7'd54: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd55: i = mk(OP_MUL, SEL_K01, SEL_Y1, SEL_ZERO);
            7'd56: i = mk(OP_ACCADD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd57: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_C0);
            7'd58: i = mk(OP_MUL, SEL_K10, SEL_Y0, SEL_ZERO);
            7'd59: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd60: i = mk(OP_MUL, SEL_K11, SEL_Y1, SEL_ZERO);
            7'd61: i = mk(OP_ACCADD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd62: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_C1);
            7'd63: i = mk(OP_ADD, SEL_HP, SEL_C0, SEL_H);
            7'd64: i = mk(OP_ADD, SEL_VP, SEL_C1, SEL_V);
            7'd65: i = mk(OP_MUL, SEL_K00, SEL_P00, SEL_ZERO);
            7'd66: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd67: i = mk(OP_MUL, SEL_K01, SEL_P01, SEL_ZERO);
            7'd68: i = mk(OP_ACCADD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd69: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd70: i = mk(OP_SUB, SEL_P00, SEL_T, SEL_PA);
            7'd71: i = mk(OP_MUL, SEL_K00, SEL_P01, SEL_ZERO);
            7'd72: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd73: i = mk(OP_MUL, SEL_K01, SEL_P11, SEL_ZERO);
            7'd74: i = mk(OP_ACCADD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd75: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd76: i = mk(OP_SUB, SEL_P01, SEL_T, SEL_PC);
            7'd77: i = mk(OP_MUL, SEL_K10, SEL_P01, SEL_ZERO);
            7'd78: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd79: i = mk(OP_MUL, SEL_K11, SEL_P11, SEL_ZERO);
            7'd80: i = mk(OP_ACCADD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd81: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd82: i = mk(OP_SUB, SEL_P11, SEL_T, SEL_PV);
            7'd83: i = mk(OP_ADD, SEL_H, SEL_ZERO, SEL_PRI);
            7'd84: i = mk(OP_LEARN, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd85: i = mk(OP_MUL, SEL_GAIN, SEL_C1, SEL_ZERO);
            7'd86: i = mk(OP_LD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd87: i = mk(OP_RND, SEL_ZERO, SEL_ZERO, SEL_T);
            7'd88: i = mk(OP_BADD, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            7'd89: i = mk(OP_BUMP, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            default: i = mk(OP_NOP, SEL_ZERO, SEL_ZERO, SEL_ZERO);
        endcase
        return i;
    endfunction

endpackage

FILE: sv/altitude_kalman_with_bias_top.sv
// top level: register port, sequencer and datapath of the altitude filter
`timescale 1ns / 1ps

// Two-state altitude and vertical-velocity Kalman filter with accelerometer
// bias learning, Q16.16 throughout with saturation. One word in gives one word
// out. Predict with update runs the serial gain divider, which produces the four
// gain entries one after another at one quotient bit a cycle; all products
// share one registered 32x32 multiplier.
// One word is worked on at a time; a finished word waits in an output register.

module altitude_kalman_with_bias_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  akwb_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output akwb_pkg::t_out_word                o_out_word,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [akwb_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    akwb_pkg::t_cfg  r_cfg;
    akwb_pkg::t_cmd  cmd;
    akwb_pkg::t_stat stat;
    logic            wr;
    logic [2:0]      idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[akwb_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_time       <= akwb_pkg::STEP_TIME_RST;
            r_cfg.alt_process_var <= akwb_pkg::ALT_PV_RST;
            r_cfg.vel_process_var <= akwb_pkg::VEL_PV_RST;
            r_cfg.alt_meas_var    <= akwb_pkg::ALT_MV_RST;
            r_cfg.vel_meas_var    <= akwb_pkg::VEL_MV_RST;
            r_cfg.bias_gain       <= akwb_pkg::BIAS_GAIN_RST;
            r_cfg.settle_count    <= akwb_pkg::SETTLE_RST;
        end else if (wr) begin
            unique case (idx)
                akwb_pkg::REG_STEP_TIME: r_cfg.step_time <= pwdata[16:0];
                akwb_pkg::REG_ALT_PV:    r_cfg.alt_process_var <= pwdata[30:0];
                akwb_pkg::REG_VEL_PV:    r_cfg.vel_process_var <= pwdata[30:0];
                akwb_pkg::REG_ALT_MV:    r_cfg.alt_meas_var <= pwdata[30:0];
                akwb_pkg::REG_VEL_MV:    r_cfg.vel_meas_var <= pwdata[30:0];
                akwb_pkg::REG_BIAS_GAIN: r_cfg.bias_gain <= pwdata[16:0];
                akwb_pkg::REG_SETTLE:    r_cfg.settle_count <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            akwb_pkg::REG_STEP_TIME: prdata = {15'd0, r_cfg.step_time};
            akwb_pkg::REG_ALT_PV:    prdata = {1'b0, r_cfg.alt_process_var};
            akwb_pkg::REG_VEL_PV:    prdata = {1'b0, r_cfg.vel_process_var};
            akwb_pkg::REG_ALT_MV:    prdata = {1'b0, r_cfg.alt_meas_var};
            akwb_pkg::REG_VEL_MV:    prdata = {1'b0, r_cfg.vel_meas_var};
            akwb_pkg::REG_BIAS_GAIN: prdata = {15'd0, r_cfg.bias_gain};
            akwb_pkg::REG_SETTLE:    prdata = {16'd0, r_cfg.settle_count};
            default:                 prdata = '0;
        endcase
    end

    akwb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_word.operation),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    akwb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule

FILE: sv/akwb_div.sv
// serial restoring divider for the gain entries, one quotient bit a cycle
`timescale 1ns / 1ps

module akwb_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [akwb_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [63:0]                       r_num;
    logic [63:0]                       r_den;
    logic [63:0]                       r_rem;
    logic [31:0]                       r_q;
    logic                              r_ovf;
    logic                              r_neg;
    logic                              r_zero;
    logic [64:0]                       rem_sh;
    logic                              ge;
    logic [64:0]                       rem_sub;
    logic                              big;

    assign rem_sh  = {r_rem, r_num[63]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num[63] ? 64'(-i_num) : i_num;
                r_den  <= i_den[63] ? 64'(-i_den) : i_den;
                r_neg  <= i_num[63] ^ i_den[63];
                r_zero <= (i_den == 64'sd0);
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= akwb_pkg::DIV_CNT_W'(akwb_pkg::DIV_ITERS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[63:0] : rem_sh[63:0];
                r_q   <= {r_q[30:0], ge};
                r_ovf <= r_ovf | r_q[31];
                r_num <= {r_num[62:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign big = r_ovf | r_q[31];

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = big ? 32'sh8000_0000 : 32'(-$signed(r_q));
        end else begin
            o_quot = big ? 32'sh7FFF_FFFF : $signed(r_q);
        end
    end

    assign o_done = r_done;

endmodule

FILE: sv/akwb_dp.sv
// filter datapath: state, shared multiplier, accumulator and gain divider
`timescale 1ns / 1ps

module akwb_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  akwb_pkg::t_cfg      i_cfg,
    input  akwb_pkg::t_in_word  i_in_word,
    input  akwb_pkg::t_cmd      i_cmd,
    output akwb_pkg::t_stat     o_stat,
    output akwb_pkg::t_out_word o_out_word
);

    localparam logic signed [65:0] HALF = 66'sd1 <<< (akwb_pkg::FRAC_BITS - 1);
    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    logic signed [31:0] r_h, r_v, r_pa, r_pc, r_pv, r_pri, r_bias;
    logic [15:0]        r_count;
    logic               r_learn;
    logic signed [31:0] r_accel, r_zh, r_zv;
    logic signed [31:0] r_t, r_hp, r_vp, r_p00, r_p01, r_p11, r_s00, r_s11;
    logic signed [31:0] r_k00, r_k01, r_k10, r_k11, r_y0, r_y1, r_c0, r_c1;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [63:0] r_det;
    akwb_pkg::t_out_word r_out;

    logic signed [31:0] opa, opb, rnd, sum, dif, wval, quot;
    logic signed [65:0] rsum, rsh;
    logic               wen, div_done;

    function automatic logic signed [31:0] sel_val(input akwb_pkg::t_sel s,
        input logic signed [31:0] h, input logic signed [31:0] v,
        input logic signed [31:0] pa, input logic signed [31:0] pc,
        input logic signed [31:0] pv, input logic signed [31:0] pri,
        input logic signed [31:0] bias, input akwb_pkg::t_cfg c,
        input logic signed [31:0] acc, input logic signed [31:0] zh,
        input logic signed [31:0] zv, input logic signed [31:0] t,
        input logic signed [31:0] hp, input logic signed [31:0] vp,
        input logic signed [31:0] p00, input logic signed [31:0] p01,
        input logic signed [31:0] p11, input logic signed [31:0] s00,
        input logic signed [31:0] s11, input logic signed [31:0] k00,
        input logic signed [31:0] k01, input logic signed [31:0] k10,
        input logic signed [31:0] k11, input logic signed [31:0] y0,
        input logic signed [31:0] y1, input logic signed [31:0] c0,
        input logic signed [31:0] c1);
        logic signed [31:0] r;
        case (s)
            akwb_pkg::SEL_H:    r = h;
            akwb_pkg::SEL_V:    r = v;
            akwb_pkg::SEL_PA:   r = pa;
            akwb_pkg::SEL_PC:   r = pc;
            akwb_pkg::SEL_PV:   r = pv;
            akwb_pkg::SEL_PRI:  r = pri;
            akwb_pkg::SEL_BIAS: r = bias;
            akwb_pkg::SEL_DT:   r = $signed({15'd0, c.step_time});
            akwb_pkg::SEL_QA:   r = $signed({1'b0, c.alt_process_var});
            akwb_pkg::SEL_QV:   r = $signed({1'b0, c.vel_process_var});
            akwb_pkg::SEL_RA:   r = $signed({1'b0, c.alt_meas_var});
            akwb_pkg::SEL_RV:   r = $signed({1'b0, c.vel_meas_var});
            akwb_pkg::SEL_GAIN: r = $signed({15'd0, c.bias_gain});
            akwb_pkg::SEL_ACC:  r = acc;
            akwb_pkg::SEL_ZH:   r = zh;
            akwb_pkg::SEL_ZV:   r = zv;
            akwb_pkg::SEL_T:    r = t;
            akwb_pkg::SEL_HP:   r = hp;
            akwb_pkg::SEL_VP:   r = vp;
            akwb_pkg::SEL_P00:  r = p00;
            akwb_pkg::SEL_P01:  r = p01;
            akwb_pkg::SEL_P11:  r = p11;
            akwb_pkg::SEL_S00:  r = s00;
            akwb_pkg::SEL_S11:  r = s11;
            akwb_pkg::SEL_K00:  r = k00;
            akwb_pkg::SEL_K01:  r = k01;
            akwb_pkg::SEL_K10:  r = k10;
            akwb_pkg::SEL_K11:  r = k11;
            akwb_pkg::SEL_Y0:   r = y0;
            akwb_pkg::SEL_Y1:   r = y1;
            akwb_pkg::SEL_C0:   r = c0;
            akwb_pkg::SEL_C1:   r = c1;
            default:            r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s[32] != s[31]) begin
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    assign opa = sel_val(i_cmd.a, r_h, r_v, r_pa, r_pc, r_pv, r_pri, r_bias, i_cfg,
                         r_accel, r_zh, r_zv, r_t, r_hp, r_vp, r_p00, r_p01, r_p11,
                         r_s00, r_s11, r_k00, r_k01, r_k10, r_k11, r_y0, r_y1,
                         r_c0, r_c1);
    assign opb = sel_val(i_cmd.b, r_h, r_v, r_pa, r_pc, r_pv, r_pri, r_bias, i_cfg,
                         r_accel, r_zh, r_zv, r_t, r_hp, r_vp, r_p00, r_p01, r_p11,
                         r_s00, r_s11, r_k00, r_k01, r_k10, r_k11, r_y0, r_y1,
                         r_c0, r_c1);

    assign sum = sat33(33'(opa) + 33'(opb));
    assign dif = sat33(33'(opa) - 33'(opb));

    // round half up, floor by the fraction, saturate
    assign rsum = r_acc + HALF;
    assign rsh  = rsum >>> akwb_pkg::FRAC_BITS;
    always_comb begin
        if (rsh > MAX66) begin
            rnd = 32'sh7FFF_FFFF;
        end else if (rsh < MIN66) begin
            rnd = 32'sh8000_0000;
        end else begin
            rnd = rsh[31:0];
        end
    end

    always_comb begin
        wen  = 1'b1;
        wval = '0;
        case (i_cmd.op)
            akwb_pkg::OP_RND:   wval = rnd;
            akwb_pkg::OP_ADD:   wval = sum;
            akwb_pkg::OP_SUB:   wval = dif;
            akwb_pkg::OP_DIVWR: wval = quot;
            default:            wen = 1'b0;
        endcase
    end

    akwb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == akwb_pkg::OP_DIV),
        .i_num   (r_acc[63:0]),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= '0;
            r_v     <= '0;
            r_pri   <= '0;
            r_bias  <= '0;
            r_pa    <= $signed({1'b0, akwb_pkg::ALT_MV_RST});
            r_pc    <= '0;
            r_pv    <= $signed({1'b0, akwb_pkg::VEL_MV_RST});
            r_count <= '0;
            r_learn <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                r_h     <= '0;
                r_v     <= '0;
                r_pri   <= '0;
                r_bias  <= '0;
                r_pa    <= $signed({1'b0, i_cfg.alt_meas_var});
                r_pc    <= '0;
                r_pv    <= $signed({1'b0, i_cfg.vel_meas_var});
                r_count <= '0;
                r_learn <= 1'b0;
            end
            if (wen) begin
                case (i_cmd.dst)
                    akwb_pkg::SEL_H:   r_h <= wval;
                    akwb_pkg::SEL_V:   r_v <= wval;
                    akwb_pkg::SEL_PA:  r_pa <= wval;
                    akwb_pkg::SEL_PC:  r_pc <= wval;
                    akwb_pkg::SEL_PV:  r_pv <= wval;
                    akwb_pkg::SEL_PRI: r_pri <= wval;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                akwb_pkg::OP_PCOMMIT: begin
                    r_h  <= r_hp;
                    r_v  <= r_vp;
                    r_pa <= r_p00;
                    r_pc <= r_p01;
                    r_pv <= r_p11;
                    if (r_count != 16'hFFFF) r_count <= r_count + 16'd1;
                end
                akwb_pkg::OP_BUMP: begin
                    if (r_count != 16'hFFFF) r_count <= r_count + 16'd1;
                end
                akwb_pkg::OP_LEARN: begin
                    if (r_count > i_cfg.settle_count) r_learn <= 1'b1;
                end
                akwb_pkg::OP_BADD: begin
                    if (r_learn) r_bias <= sat33(33'(r_bias) + 33'(r_t));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_accel <= i_in_word.accel_down;
            r_zh    <= i_in_word.alt_meas;
            r_zv    <= i_in_word.vel_meas;
        end
        if (wen) begin
            case (i_cmd.dst)
                akwb_pkg::SEL_T:   r_t <= wval;
                akwb_pkg::SEL_HP:  r_hp <= wval;
                akwb_pkg::SEL_VP:  r_vp <= wval;
                akwb_pkg::SEL_P00: r_p00 <= wval;
                akwb_pkg::SEL_P01: r_p01 <= wval;
                akwb_pkg::SEL_P11: r_p11 <= wval;
                akwb_pkg::SEL_S00: r_s00 <= wval;
                akwb_pkg::SEL_S11: r_s11 <= wval;
                akwb_pkg::SEL_K00: r_k00 <= wval;
                akwb_pkg::SEL_K01: r_k01 <= wval;
                akwb_pkg::SEL_K10: r_k10 <= wval;
                akwb_pkg::SEL_K11: r_k11 <= wval;
                akwb_pkg::SEL_Y0:  r_y0 <= wval;
                akwb_pkg::SEL_Y1:  r_y1 <= wval;
                akwb_pkg::SEL_C0:  r_c0 <= wval;
                akwb_pkg::SEL_C1:  r_c1 <= wval;
                default: ;
            endcase
        end
        case (i_cmd.op)
            akwb_pkg::OP_MUL:    r_prod <= opa * opb;
            akwb_pkg::OP_LD:     r_acc <= 66'(r_prod);
            akwb_pkg::OP_ACCADD: r_acc <= r_acc + 66'(r_prod);
            akwb_pkg::OP_ACCSUB: r_acc <= r_acc - 66'(r_prod);
            akwb_pkg::OP_DET:    r_det <= r_acc[63:0];
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out.alt_est  <= r_h;
            r_out.vel_est  <= r_v;
            r_out.bias_est <= r_bias;
            r_out.settled  <= r_learn;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_out_word = r_out;

endmodule

FILE: sv/akwb_ctrl.sv
// sequencer: steps the microprogram and runs both handshakes
`timescale 1ns / 1ps

module akwb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_op,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  akwb_pkg::t_stat i_stat,
    output akwb_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIVW, S_HOLD} t_state;

    t_state                      r_state;
    logic [akwb_pkg::PC_W-1:0]   r_pc;
    logic [1:0]                  r_op;
    logic                        r_out_valid;
    akwb_pkg::t_instr            instr;
    logic                        accept;
    logic                        out_free;
    logic                        is_pred;

    assign instr    = akwb_pkg::prog(r_pc);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_pred  = (r_op == akwb_pkg::OPC_PREDICT);

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = akwb_pkg::OP_NOP;
        o_cmd.a        = instr.a;
        o_cmd.b        = instr.b;
        o_cmd.dst      = instr.dst;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = accept;
                o_cmd.init  = accept && (i_op == akwb_pkg::OPC_INIT);
            end
            S_RUN: begin
                o_cmd.op = instr.op;
                if (r_pc == akwb_pkg::PC_PRED_END && !is_pred) o_cmd.op = akwb_pkg::OP_NOP;
            end
            S_DIVW: begin
                o_cmd.op = i_stat.div_done ? akwb_pkg::OP_DIVWR : akwb_pkg::OP_NOP;
            end
            S_HOLD: begin
                o_cmd.load_out = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_op        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op <= i_op;
                        r_pc <= '0;
                        if (i_op == akwb_pkg::OPC_PREDICT || i_op == akwb_pkg::OPC_UPDATE) begin
                            r_state <= S_RUN;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_RUN: begin
                    if ((r_pc == akwb_pkg::PC_PRED_END && is_pred) ||
                        r_pc == akwb_pkg::PC_LAST) begin
                        r_state <= S_HOLD;
                    end else if (instr.op == akwb_pkg::OP_DIV) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                S_DIVW: begin
                    if (i_stat.div_done) begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_HOLD: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_hold_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished word not presented");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_pc <= akwb_pkg::PC_LAST))
        else $error("program counter out of range");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIVW))
        else $error("divider finished outside its wait state");
`endif

endmodule

FILE: tb/altitude_kalman_with_bias_top_tb.sv
// testbench for the altitude kalman filter: predicting scoreboard and random stimulus
`timescale 1ns / 1ps

module altitude_kalman_with_bias_top_tb;

    typedef logic signed [127:0] t_wide;

    class kalman_scoreboard;
        akwb_pkg::t_cfg cfg;
        logic signed [31:0] alt, vel, pa, pc, pv, pri, bias;
        logic [15:0] iters;
        logic learning;
        akwb_pkg::t_out_word pending[$];
        int errors;

        function new();
            cfg.step_time = akwb_pkg::STEP_TIME_RST;
            cfg.alt_process_var = akwb_pkg::ALT_PV_RST;
            cfg.vel_process_var = akwb_pkg::VEL_PV_RST;
            cfg.alt_meas_var = akwb_pkg::ALT_MV_RST;
            cfg.vel_meas_var = akwb_pkg::VEL_MV_RST;
            cfg.bias_gain = akwb_pkg::BIAS_GAIN_RST;
            cfg.settle_count = akwb_pkg::SETTLE_RST;
            errors = 0;
            clear_filter();
        endfunction

        function void clear_filter();
            alt = 0;
            vel = 0;
            pri = 0;
            bias = 0;
            pc = 0;
            pa = cfg.alt_meas_var;
            pv = cfg.vel_meas_var;
            iters = 0;
            learning = 0;
        endfunction

        function void write_reg(akwb_pkg::t_reg_idx idx, logic [31:0] v);
            case (idx)
                akwb_pkg::REG_STEP_TIME: cfg.step_time = v[16:0];
                akwb_pkg::REG_ALT_PV:    cfg.alt_process_var = v[30:0];
                akwb_pkg::REG_VEL_PV:    cfg.vel_process_var = v[30:0];
                akwb_pkg::REG_ALT_MV:    cfg.alt_meas_var = v[30:0];
                akwb_pkg::REG_VEL_MV:    cfg.vel_meas_var = v[30:0];
                akwb_pkg::REG_BIAS_GAIN: cfg.bias_gain = v[16:0];
                akwb_pkg::REG_SETTLE:    cfg.settle_count = v[15:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] sat(t_wide x);
            if (x > 128'sd2147483647) return 32'sh7fffffff;
            if (x < -128'sd2147483648) return 32'sh80000000;
            return x[31:0];
        endfunction

        function t_wide rnd(t_wide x);
            return (x + 128'sd32768) >>> akwb_pkg::FRAC_BITS;
        endfunction

        function t_wide mul(t_wide a, t_wide b);
            return a * b;
        endfunction

        function logic signed [31:0] fadd(t_wide a, t_wide b);
            return sat(a + b);
        endfunction

        function logic signed [31:0] fsub(t_wide a, t_wide b);
            return sat(a - b);
        endfunction

        function logic signed [31:0] fmul(t_wide a, t_wide b);
            return sat(rnd(a * b));
        endfunction

        function logic signed [31:0] fmac2(t_wide a, t_wide b, t_wide c, t_wide d);
            return sat(rnd(a * b + c * d));
        endfunction

        function logic signed [31:0] gain(t_wide num, t_wide det);
            t_wide un, ud, q;
            logic neg;
            if (det == 0) return 0;
            neg = (num < 0) != (det < 0);
            un = (num < 0) ? -num : num;
            ud = (det < 0) ? -det : det;
            q = (un <<< akwb_pkg::FRAC_BITS) / ud;
            if (neg) return (q >= 128'sd2147483648) ? 32'sh80000000 : sat(-q);
            return sat(q);
        endfunction

        function void note(akwb_pkg::t_in_word w);
            logic signed [31:0] hp, vp, p00, p01, p11, s00, s01, s11;
            logic signed [31:0] k00, k01, k10, k11, y0, y1, c0, c1;
            t_wide dt, det;
            akwb_pkg::t_out_word r;
            dt = cfg.step_time;
            if (w.operation == akwb_pkg::OPC_INIT) begin
                clear_filter();
            end else if (w.operation == akwb_pkg::OPC_PREDICT ||
                         w.operation == akwb_pkg::OPC_UPDATE) begin
                hp = fsub(alt, fmul(vel, dt));
                vp = fadd(vel, fmul(fadd(w.accel_down, bias), dt));
                p01 = fsub(pc, fmul(dt, pv));
                p00 = fadd(fsub(fsub(pa, fmul(dt, pc)), fmul(dt, p01)), cfg.alt_process_var);
                p11 = fadd(pv, cfg.vel_process_var);
                if (w.operation == akwb_pkg::OPC_PREDICT) begin
                    alt = hp;
                    vel = vp;
                    pa = p00;
                    pc = p01;
                    pv = p11;
                end else begin
                    s00 = fadd(p00, cfg.alt_meas_var);
                    s01 = p01;
                    s11 = fadd(p11, cfg.vel_meas_var);
                    det = mul(s00, s11) - mul(s01, s01);
                    k00 = gain(mul(p00, s11) - mul(p01, s01), det);
                    k01 = gain(mul(p01, s00) - mul(p00, s01), det);
                    k10 = gain(mul(p01, s11) - mul(p11, s01), det);
                    k11 = gain(mul(p11, s00) - mul(p01, s01), det);
                    y0 = fsub(w.alt_meas, pri);
                    y1 = fsub(w.vel_meas, vp);
                    c0 = fmac2(k00, y0, k01, y1);
                    c1 = fmac2(k10, y0, k11, y1);
                    alt = fadd(hp, c0);
                    vel = fadd(vp, c1);
                    pa = fsub(p00, fmac2(k00, p00, k01, p01));
                    pc = fsub(p01, fmac2(k00, p01, k01, p11));
                    pv = fsub(p11, fmac2(k10, p01, k11, p11));
                    pri = alt;
                    if (iters > cfg.settle_count) learning = 1;
                    if (learning) bias = fadd(bias, fmul(cfg.bias_gain, c1));
                end
                if (iters != 16'hffff) iters = iters + 1;
            end
            r.alt_est = alt;
            r.vel_est = vel;
            r.bias_est = bias;
            r.settled = learning;
            pending.push_back(r);
        endfunction

        function void check(akwb_pkg::t_out_word got);
            akwb_pkg::t_out_word want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.alt_est !== want.alt_est) begin
                $display("%0t: alt_est expected %h actual %h", $time, want.alt_est, got.alt_est);
                errors++;
            end
            if (got.vel_est !== want.vel_est) begin
                $display("%0t: vel_est expected %h actual %h", $time, want.vel_est, got.vel_est);
                errors++;
            end
            if (got.bias_est !== want.bias_est) begin
                $display("%0t: bias_est expected %h actual %h", $time, want.bias_est,
                         got.bias_est);
                errors++;
            end
            if (got.settled !== want.settled) begin
                $display("%0t: settled expected %b actual %b", $time, want.settled, got.settled);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    akwb_pkg::t_in_word i_in_word;
    logic o_out_valid;
    logic i_out_stall;
    akwb_pkg::t_out_word o_out_word;
    logic psel, penable, pwrite;
    logic [akwb_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    kalman_scoreboard sb = new();
    logic tx_quiet = 0;
    logic rx_quiet = 0;
    logic hold_req = 0;
    int quiet_cycles = 0;

    altitude_kalman_with_bias_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) sb.note(i_in_word);
        if (o_out_valid && !i_out_stall) sb.check(o_out_word);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stall, with a long hold-off on request
    initial begin
        i_out_stall <= 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1;
                repeat (2000) @(posedge i_clk);
                hold_req = 0;
                i_out_stall <= 0;
            end else begin
                i_out_stall <= !rx_quiet && ($urandom_range(99) < 14);
            end
        end
    end

    task automatic reg_write(akwb_pkg::t_reg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        sb.write_reg(idx, v);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_word(akwb_pkg::t_opc op, int acc, int zh, int zv);
        if (!tx_quiet && $urandom_range(99) < 14) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_word.operation <= op;
        i_in_word.accel_down <= acc;
        i_in_word.alt_meas <= zh;
        i_in_word.vel_meas <= zv;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic int pick(int span);
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic send_random(int n);
        int r;
        akwb_pkg::t_opc op;
        repeat (n) begin
            r = $urandom_range(99);
            op = (r < 3) ? akwb_pkg::OPC_INIT : (r < 6) ? akwb_pkg::OPC_NONE :
                 (r < 50) ? akwb_pkg::OPC_PREDICT : akwb_pkg::OPC_UPDATE;
            send_word(op, pick(20 * 65536), pick(300 * 65536), pick(50 * 65536));
        end
    endtask

    task automatic write_all(logic [31:0] dt, logic [31:0] qa, logic [31:0] qv,
                             logic [31:0] ra, logic [31:0] rv, logic [31:0] g,
                             logic [31:0] settle);
        i_in_valid <= 0;
        drain();
        reg_write(akwb_pkg::REG_STEP_TIME, dt);
        reg_write(akwb_pkg::REG_ALT_PV, qa);
        reg_write(akwb_pkg::REG_VEL_PV, qv);
        reg_write(akwb_pkg::REG_ALT_MV, ra);
        reg_write(akwb_pkg::REG_VEL_MV, rv);
        reg_write(akwb_pkg::REG_BIAS_GAIN, g);
        reg_write(akwb_pkg::REG_SETTLE, settle);
    endtask

    function automatic logic [31:0] rand_var();
        if ($urandom_range(3) == 0) return $urandom & 32'h7fffffff;
        return $urandom_range(0, 70000);
    endfunction

    initial begin
        i_rst_n <= 0;
        i_in_valid <= 0;
        i_in_word <= '0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes of each field, every code
        send_word(akwb_pkg::OPC_PREDICT, 0, 0, 0);
        send_word(akwb_pkg::OPC_UPDATE, 0, 0, 0);
        send_word(akwb_pkg::OPC_NONE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_word(akwb_pkg::OPC_PREDICT, 32'h7fffffff, 0, 0);
        send_word(akwb_pkg::OPC_PREDICT, 32'h80000000, 0, 0);
        send_word(akwb_pkg::OPC_UPDATE, 0, 32'h7fffffff, 32'h7fffffff);
        send_word(akwb_pkg::OPC_UPDATE, 0, 32'h80000000, 32'h80000000);
        send_word(akwb_pkg::OPC_UPDATE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_word(akwb_pkg::OPC_INIT, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_word(akwb_pkg::OPC_NONE, 0, 0, 0);
        send_word(akwb_pkg::OPC_UPDATE, 65536, 100 * 65536, -65536);
        send_random(250);

        write_all(65536, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65536, 0);
        tx_quiet = 1;
        rx_quiet = 1;
        send_word(akwb_pkg::OPC_INIT, 0, 0, 0);
        send_word(akwb_pkg::OPC_UPDATE, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_word(akwb_pkg::OPC_PREDICT, 32'h80000000, 0, 0);
        send_word(akwb_pkg::OPC_UPDATE, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_random(150);
        tx_quiet = 0;
        rx_quiet = 0;

        // singular innovation covariance
        write_all(0, 0, 0, 0, 0, 0, 0);
        send_word(akwb_pkg::OPC_INIT, 0, 0, 0);
        send_word(akwb_pkg::OPC_UPDATE, 1000, 5 * 65536, 65536);
        send_word(akwb_pkg::OPC_UPDATE, -1000, -5 * 65536, -65536);
        send_random(100);

        repeat (3) begin
            write_all($urandom_range(0, 65536), rand_var(), rand_var(), rand_var(), rand_var(),
                      $urandom_range(0, 65536), $urandom_range(0, 20));
            send_word(akwb_pkg::OPC_INIT, 0, 0, 0);
            hold_req = 1;
            send_random(150);
        end

        write_all(akwb_pkg::STEP_TIME_RST, akwb_pkg::ALT_PV_RST, akwb_pkg::VEL_PV_RST,
                  akwb_pkg::ALT_MV_RST, akwb_pkg::VEL_MV_RST, akwb_pkg::BIAS_GAIN_RST, 5);
        send_word(akwb_pkg::OPC_INIT, 0, 0, 0);
        send_random(250);
        i_in_valid <= 0;

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

FILE: altitude_kalman_with_bias_top.f
sv/akwb_pkg.sv
sv/akwb_div.sv
sv/akwb_dp.sv
sv/akwb_ctrl.sv
sv/altitude_kalman_with_bias_top.sv
tb/altitude_kalman_with_bias_top_tb.sv
